// ===== rtl/core/cmpt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RGBA color matrix transform.
package cmpt_pkg;

	localparam int unsigned CH_W   = 16;
	localparam int unsigned FRAC_W = 12;
	localparam int unsigned CFG_W  = 64;
	localparam int unsigned ADDR_W = 6;
	localparam int unsigned IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_RED    = 3'd0;
	localparam logic [IDX_W-1:0] REG_GREEN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_BLUE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_ALPHA  = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd4;

	localparam logic [CFG_W-1:0] RST_RED    = 64'h0000_0000_0000_1000;
	localparam logic [CFG_W-1:0] RST_GREEN  = 64'h0000_0000_1000_0000;
	localparam logic [CFG_W-1:0] RST_BLUE   = 64'h0000_1000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ALPHA  = 64'h1000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_OFFSET = 64'h0000_0000_0000_0000;

	localparam logic [34:0]     RND_HALF = 35'd2048;
	localparam logic [CH_W-1:0] SAT_MAX  = 16'h7FFF;
	localparam logic [CH_W-1:0] SAT_MIN  = 16'h8000;

	typedef struct packed {
		logic signed [15:0] in_red;
		logic signed [15:0] in_green;
		logic signed [15:0] in_blue;
		logic signed [15:0] in_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic signed [15:0] out_red;
		logic signed [15:0] out_green;
		logic signed [15:0] out_blue;
		logic signed [15:0] out_alpha;
	} pixel_out_t;

	typedef struct packed {
		logic adv1;
		logic adv2;
		logic adv3;
		logic adv4;
	} stage_en_t;

endpackage

// ===== rtl/core/color_matrix_pixel_transform.sv =====
`timescale 1ns / 1ps
// Top level of the RGBA 4x5 affine color matrix transform.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  pix     | in        | pix_valid / pix_stall     | cmpt_pkg::pixel_in_t
//  res     | out       | res_valid / res_stall     | cmpt_pkg::pixel_out_t
//  apb     | in        | psel/penable/pwrite/pready| paddr[5:0], pwdata/prdata 64b
//
// The accepting edge loads a pixel transaction into the multiply stage; it then
// passes the partial-sum, rounding and saturation stages; the saturation register
// drives the result. The four-stage pipeline takes one pixel every cycle while
// res_stall does not back it up; the multiplier stage sets the
// clock. Each stage advances whenever it is empty or the stage after it advances,
// so bubbles collapse under a stall and nothing is lost or repeated. Reset clears
// all valid bits and loads the identity matrix with a zero offset row.
module color_matrix_pixel_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port, register i at byte address 8*i
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cmpt_pkg::ADDR_W-1:0]         paddr,
	input  logic [cmpt_pkg::CFG_W-1:0]          pwdata,
	output logic [cmpt_pkg::CFG_W-1:0]          prdata,
	output logic                                pready,
	// pixel input
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  cmpt_pkg::pixel_in_t                 pix,
	// pixel result
	output logic                                res_valid,
	input  logic                                res_stall,
	output cmpt_pkg::pixel_out_t                res
);

	logic [cmpt_pkg::CFG_W-1:0] red_q, green_q, blue_q, alpha_q, offset_q;
	logic [cmpt_pkg::IDX_W-1:0] reg_idx;
	logic                       wr_en;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	cmpt_pkg::stage_en_t en;

	logic signed [15:0] lane_res [4];

	// ---------------------------------------------------------------------
	// Configuration registers: eight bytes apart, writes beyond the list drop
	// ---------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q    <= cmpt_pkg::RST_RED;
			green_q  <= cmpt_pkg::RST_GREEN;
			blue_q   <= cmpt_pkg::RST_BLUE;
			alpha_q  <= cmpt_pkg::RST_ALPHA;
			offset_q <= cmpt_pkg::RST_OFFSET;
		end else if (wr_en) begin
			case (reg_idx)
				cmpt_pkg::REG_RED:    red_q    <= pwdata;
				cmpt_pkg::REG_GREEN:  green_q  <= pwdata;
				cmpt_pkg::REG_BLUE:   blue_q   <= pwdata;
				cmpt_pkg::REG_ALPHA:  alpha_q  <= pwdata;
				cmpt_pkg::REG_OFFSET: offset_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cmpt_pkg::REG_RED:    prdata = red_q;
			cmpt_pkg::REG_GREEN:  prdata = green_q;
			cmpt_pkg::REG_BLUE:   prdata = blue_q;
			cmpt_pkg::REG_ALPHA:  prdata = alpha_q;
			cmpt_pkg::REG_OFFSET: prdata = offset_q;
			default:              prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Pipeline control: a stage takes new data when empty or when it drains
	// ---------------------------------------------------------------------
	assign rdy4 = !vld_s4 || !res_stall;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign pix_stall = !rdy1;

	assign en.adv1 = pix_valid && rdy1;
	assign en.adv2 = vld_s1 && rdy2;
	assign en.adv3 = vld_s2 && rdy3;
	assign en.adv4 = vld_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= pix_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// ---------------------------------------------------------------------
	// One datapath per output channel; lane k takes bits 16k+15:16k of each
	// weight register and of the offset row
	// ---------------------------------------------------------------------
	for (genvar k = 0; k < 4; k++) begin : g_lane
		cmpt_lane u_lane (
			.clk     (clk),
			.en      (en),
			.pix     (pix),
			.w_red   (red_q[16*k +: 16]),
			.w_green (green_q[16*k +: 16]),
			.w_blue  (blue_q[16*k +: 16]),
			.w_alpha (alpha_q[16*k +: 16]),
			.offset  (offset_q[16*k +: 16]),
			.result  (lane_res[k])
		);
	end

	assign res_valid     = vld_s4;
	assign res.out_red   = lane_res[0];
	assign res.out_green = lane_res[1];
	assign res.out_blue  = lane_res[2];
	assign res.out_alpha = lane_res[3];

endmodule

// ===== rtl/core/cmpt_lane.sv =====
`timescale 1ns / 1ps
// One output channel datapath: four products, adder tree, rounding, saturation.
module cmpt_lane (
	input  logic                  clk,
	input  cmpt_pkg::stage_en_t   en,
	input  cmpt_pkg::pixel_in_t   pix,
	input  logic signed [15:0]    w_red,
	input  logic signed [15:0]    w_green,
	input  logic signed [15:0]    w_blue,
	input  logic signed [15:0]    w_alpha,
	input  logic signed [15:0]    offset,
	output logic signed [15:0]    result
);

	logic signed [31:0] prod_r_s1, prod_g_s1, prod_b_s1, prod_a_s1;
	logic signed [32:0] sum_a_s2;
	logic signed [33:0] sum_b_s2;
	logic        [22:0] rnd_s3;
	logic        [15:0] res_s4;

	logic [33:0] off_ext;
	logic [34:0] acc;

	assign off_ext = {{6{offset[15]}}, offset, 12'd0};
	assign acc     = {{2{sum_a_s2[32]}}, sum_a_s2} + {sum_b_s2[33], sum_b_s2} + cmpt_pkg::RND_HALF;

	always_ff @(posedge clk) begin
		if (en.adv1) begin
			prod_r_s1 <= pix.in_red   * w_red;
			prod_g_s1 <= pix.in_green * w_green;
			prod_b_s1 <= pix.in_blue  * w_blue;
			prod_a_s1 <= pix.in_alpha * w_alpha;
		end
		if (en.adv2) begin
			sum_a_s2 <= {prod_r_s1[31], prod_r_s1} + {prod_g_s1[31], prod_g_s1};
			sum_b_s2 <= {{2{prod_b_s1[31]}}, prod_b_s1} + {{2{prod_a_s1[31]}}, prod_a_s1}
				+ off_ext;
		end
		// drop the fraction: floor of the biased sum
		if (en.adv3) begin
			rnd_s3 <= acc[34:12];
		end
		if (en.adv4) begin
			if (!rnd_s3[22] && (|rnd_s3[21:15])) begin
				res_s4 <= cmpt_pkg::SAT_MAX;
			end else if (rnd_s3[22] && !(&rnd_s3[21:15])) begin
				res_s4 <= cmpt_pkg::SAT_MIN;
			end else begin
				res_s4 <= rnd_s3[15:0];
			end
		end
	end

	assign result = res_s4;

endmodule

// ===== tb/cmpt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the color matrix transform: tracks the registers, predicts pixels, compares results.
module cmpt_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [cmpt_pkg::ADDR_W-1:0]   paddr,
	input  logic [cmpt_pkg::CFG_W-1:0]    pwdata,
	input  logic                          pix_valid,
	input  logic                          pix_stall,
	input  cmpt_pkg::pixel_in_t           pix,
	input  logic                          res_valid,
	input  logic                          res_stall,
	input  cmpt_pkg::pixel_out_t          res,
	output int                            fail_count,
	output int                            pending,
	output int                            checked_count
);

	logic [cmpt_pkg::CFG_W-1:0] matrix_regs [0:4];
	cmpt_pkg::pixel_out_t       expected_pix_q [$];
	cmpt_pkg::pixel_out_t       want;
	logic [cmpt_pkg::IDX_W-1:0] widx;
	int                         fails;
	int                         seen;

	// Weighted sum per output lane, rounded half up to Q3.12, then clamped.
	function automatic cmpt_pkg::pixel_out_t transform_pixel(input cmpt_pkg::pixel_in_t p);
		logic signed [15:0]   chan [0:3];
		logic signed [15:0]   wt;
		logic signed [15:0]   lane_out [0:3];
		longint               acc;
		longint               rnd;
		cmpt_pkg::pixel_out_t o;
		chan[0] = p.in_red;
		chan[1] = p.in_green;
		chan[2] = p.in_blue;
		chan[3] = p.in_alpha;
		for (int k = 0; k < 4; k++) begin
			acc = 0;
			for (int c = 0; c < 4; c++) begin
				wt = matrix_regs[c][16*k +: 16];
				acc += longint'(chan[c]) * longint'(wt);
			end
			wt = matrix_regs[cmpt_pkg::REG_OFFSET][16*k +: 16];
			acc += longint'(wt) * 64'sd4096;
			rnd = (acc + 64'sd2048) >>> cmpt_pkg::FRAC_W;
			if (rnd > 64'sd32767)
				rnd = 64'sd32767;
			else if (rnd < -64'sd32768)
				rnd = -64'sd32768;
			lane_out[k] = rnd[15:0];
		end
		o.out_red   = lane_out[0];
		o.out_green = lane_out[1];
		o.out_blue  = lane_out[2];
		o.out_alpha = lane_out[3];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_regs[cmpt_pkg::REG_RED]    = cmpt_pkg::RST_RED;
			matrix_regs[cmpt_pkg::REG_GREEN]  = cmpt_pkg::RST_GREEN;
			matrix_regs[cmpt_pkg::REG_BLUE]   = cmpt_pkg::RST_BLUE;
			matrix_regs[cmpt_pkg::REG_ALPHA]  = cmpt_pkg::RST_ALPHA;
			matrix_regs[cmpt_pkg::REG_OFFSET] = cmpt_pkg::RST_OFFSET;
			expected_pix_q.delete();
			fails = 0;
			seen  = 0;
		end else begin
			// Register writes land at the access edge; unmapped indexes drop.
			if (psel && penable && pwrite && pready) begin
				widx = paddr[cmpt_pkg::ADDR_W-1:3];
				if (widx <= cmpt_pkg::REG_OFFSET)
					matrix_regs[widx] = pwdata;
			end
			if (pix_valid && !pix_stall)
				expected_pix_q.push_back(transform_pixel(pix));
			if (res_valid && !res_stall) begin
				seen++;
				if (expected_pix_q.size() == 0) begin
					$error("result transaction with no pixel outstanding");
					fails++;
				end else begin
					want = expected_pix_q.pop_front();
					if (res.out_red !== want.out_red) begin
						$error("out_red: expected %0d, got %0d", want.out_red, res.out_red);
						fails++;
					end
					if (res.out_green !== want.out_green) begin
						$error("out_green: expected %0d, got %0d", want.out_green,
							res.out_green);
						fails++;
					end
					if (res.out_blue !== want.out_blue) begin
						$error("out_blue: expected %0d, got %0d", want.out_blue, res.out_blue);
						fails++;
					end
					if (res.out_alpha !== want.out_alpha) begin
						$error("out_alpha: expected %0d, got %0d", want.out_alpha,
							res.out_alpha);
						fails++;
					end
				end
			end
		end
		fail_count    <= fails;
		pending       <= expected_pix_q.size();
		checked_count <= seen;
	end

endmodule

// ===== tb/tb_color_matrix_pixel_transform.sv =====
`timescale 1ns / 1ps
// Testbench top for the color matrix transform: clock, reset, stimulus and verdict.
module tb_color_matrix_pixel_transform;

	// Random pixels per register setting; eight settings make up the bulk of the run.
	localparam int PIXELS_PER_SETTING = 215;
	localparam int SETTING_COUNT      = 8;
	// Length of the output hold-off that backs the pipeline up into the input.
	localparam int HOLD_CYCLES        = 300;
	// Cycle budget for the watchdog.
	localparam int CYCLE_LIMIT        = 200000;
	// Pipeline is four deep; idle time to let it flush after the last result.
	localparam int FLUSH_CYCLES       = 8;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [cmpt_pkg::ADDR_W-1:0]   paddr     = '0;
	logic [cmpt_pkg::CFG_W-1:0]    pwdata    = '0;
	logic [cmpt_pkg::CFG_W-1:0]    prdata;
	logic                          pready;
	logic                          pix_valid = 1'b0;
	logic                          pix_stall;
	cmpt_pkg::pixel_in_t           pix       = '0;
	logic                          res_valid;
	logic                          res_stall = 1'b0;
	cmpt_pkg::pixel_out_t          res;

	// Random idling on each side, switched off for the quiet stretch.
	logic                tx_idle_en  = 1'b1;
	logic                rx_idle_en  = 1'b1;
	logic                hold_active = 1'b0;
	event                hold_start;

	int                  fail_count;
	int                  pending_count;
	int                  checked_count;
	int                  cycle_count = 0;
	int                  settings_run = 0;

	color_matrix_pixel_transform i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	cmpt_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pix_valid     (pix_valid),
		.pix_stall     (pix_stall),
		.pix           (pix),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.fail_count    (fail_count),
		.pending       (pending_count),
		.checked_count (checked_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: stall at random, or solidly while a hold-off is running.
	always @(posedge clk) begin
		res_stall <= hold_active || (rx_idle_en && $urandom_range(0, 99) < 10);
	end

	// Hold-off timer; counts its own cycles so the sender keeps pushing meanwhile.
	initial begin
		forever begin
			@(hold_start);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// Offer one pixel and hold it until the block takes it. Valid stays high on
	// return so back-to-back pixels go out without a bubble.
	task automatic send_pixel(input cmpt_pkg::pixel_in_t p);
		while (tx_idle_en && $urandom_range(0, 99) < 10) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
	endtask

	// Drop valid and wait until every predicted pixel has come back. The first
	// wait lets the checker's count catch up with the last accepted pixel.
	task automatic drain_pixels();
		pix_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	// APB write: setup, access, then idle so the next write starts clean.
	task automatic cfg_write(input logic [cmpt_pkg::IDX_W-1:0] idx,
			input logic [cmpt_pkg::CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_matrix(input logic [cmpt_pkg::CFG_W-1:0] r,
			input logic [cmpt_pkg::CFG_W-1:0] g,
			input logic [cmpt_pkg::CFG_W-1:0] b, input logic [cmpt_pkg::CFG_W-1:0] a,
			input logic [cmpt_pkg::CFG_W-1:0] ofs);
		cfg_write(cmpt_pkg::REG_RED, r);
		cfg_write(cmpt_pkg::REG_GREEN, g);
		cfg_write(cmpt_pkg::REG_BLUE, b);
		cfg_write(cmpt_pkg::REG_ALPHA, a);
		cfg_write(cmpt_pkg::REG_OFFSET, ofs);
		settings_run++;
	endtask

	function automatic logic [cmpt_pkg::CFG_W-1:0] rand_reg();
		return {$urandom, $urandom};
	endfunction

	// Four lanes, each uniform in [-span, span]; keeps sums mostly out of saturation.
	function automatic logic [cmpt_pkg::CFG_W-1:0] narrow_lanes(input int span);
		logic [cmpt_pkg::CFG_W-1:0] w;
		int                         v;
		for (int k = 0; k < 4; k++) begin
			v = int'($urandom_range(0, 2 * span)) - span;
			w[16*k +: 16] = v[15:0];
		end
		return w;
	endfunction

	// Mostly full-range channels, with the extremes and small values mixed in.
	function automatic logic [15:0] rand_channel();
		int v;
		case ($urandom_range(0, 9))
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				v = int'($urandom_range(0, 16384)) - 8192;
				return v[15:0];
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	function automatic cmpt_pkg::pixel_in_t rand_pixel();
		cmpt_pkg::pixel_in_t p;
		p.in_red   = rand_channel();
		p.in_green = rand_channel();
		p.in_blue  = rand_channel();
		p.in_alpha = rand_channel();
		return p;
	endfunction

	// Program the matrix for one numbered setting.
	task automatic program_setting(input int setting);
		case (setting)
			// identity weights with a small random bias
			0: begin
				load_matrix(cmpt_pkg::RST_RED, cmpt_pkg::RST_GREEN, cmpt_pkg::RST_BLUE,
					cmpt_pkg::RST_ALPHA, narrow_lanes(2048));
			end
			// every register at a range extreme: all ones, all zeros, lane max, lane min
			3: begin
				load_matrix('1, '0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, '1);
			end
			// full-range registers; most outputs clamp
			2, 5: begin
				load_matrix(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
			end
			// back to the reset matrix
			6: begin
				load_matrix(cmpt_pkg::RST_RED, cmpt_pkg::RST_GREEN, cmpt_pkg::RST_BLUE,
					cmpt_pkg::RST_ALPHA, cmpt_pkg::RST_OFFSET);
			end
			default: begin
				load_matrix(narrow_lanes(4096), narrow_lanes(4096), narrow_lanes(4096),
					narrow_lanes(4096), narrow_lanes(4096));
			end
		endcase
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset matrix passes pixels through: check extremes and bit patterns.
		send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_pixel('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		send_pixel('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
		send_pixel('{16'h1000, 16'hF000, 16'h0001, 16'hFFFF});
		send_pixel('{16'h04D2, 16'h8000, 16'h7FFF, 16'h0000});
		send_pixel('{16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA});
		send_pixel('{16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF});
		drain_pixels();

		// Unit weight from red into every lane: exercise rounding, ties go up.
		load_matrix(64'h0001_0001_0001_0001, '0, '0, '0, '0);
		send_pixel('{16'h0800, 16'h7FFF, 16'h8000, 16'h7FFF});   // +0.5 lsb -> 1
		send_pixel('{16'hF800, 16'h0000, 16'h0000, 16'h0000});   // -0.5 lsb -> 0
		send_pixel('{16'h07FF, 16'h0000, 16'h0000, 16'h0000});   // just under half -> 0
		send_pixel('{16'hF7FF, 16'h0000, 16'h0000, 16'h0000});   // just past -half -> -1
		send_pixel('{16'h1800, 16'h0000, 16'h0000, 16'h0000});   // +1.5 lsb -> 2
		send_pixel('{16'hE800, 16'h0000, 16'h0000, 16'h0000});   // -1.5 lsb -> -1
		drain_pixels();

		// Extreme weights and offsets: drive every lane into both clamps.
		load_matrix(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
			64'h8000_8000_8000_8000, 64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_0000_7FFF);
		send_pixel('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
		send_pixel('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
		send_pixel('{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
		send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_pixel('{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
		drain_pixels();

		// Writes past the last register must leave the matrix alone.
		cfg_write(cmpt_pkg::REG_OFFSET + 3'd1, rand_reg());
		cfg_write(cmpt_pkg::REG_OFFSET + 3'd2, rand_reg());
		cfg_write(cmpt_pkg::REG_OFFSET + 3'd3, rand_reg());
		send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		send_pixel('{16'h1000, 16'hF000, 16'h0800, 16'hF800});
		drain_pixels();

		for (int s = 0; s < SETTING_COUNT; s++) begin
			program_setting(s);
			if (s == 2) begin
				// Stall the output for a long stretch while pixels keep coming.
				-> hold_start;
			end
			if (s == 5) begin
				tx_idle_en <= 1'b0;
				rx_idle_en <= 1'b0;
			end else begin
				tx_idle_en <= 1'b1;
				rx_idle_en <= 1'b1;
			end
			for (int n = 0; n < PIXELS_PER_SETTING; n++)
				send_pixel(rand_pixel());
			drain_pixels();
		end

		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("Summary: %0d pixel transactions checked over %0d matrix settings,",
			checked_count, settings_run);
		$display("  covering pass-through, rounding ties, clamping and a long output stall.");
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cmpt_pkg.sv
rtl/core/cmpt_lane.sv
rtl/core/color_matrix_pixel_transform.sv
tb/cmpt_checker.sv
tb/tb_color_matrix_pixel_transform.sv
